[rtl/sbc_pkg.sv]
// shared types, codes, widths and reset values for the cover position controller
// no dependencies; every other file imports this package

package sbc_pkg;

  localparam int CNT_W      = 24;
  localparam int POS_W      = 15;
  localparam int TGT_W      = 7;
  localparam int TIME_W     = 32;
  localparam int CFG16_W    = 16;
  localparam int CPH_W      = 12;
  localparam int TOL_W      = 7;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // non-negative part of a signed count is divided one quotient bit per cycle
  localparam int DIV_STEPS  = CNT_W - 1;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_STOP   = 2'd1,
    CMD_TARGET = 2'd2
  } cmd_code_t;

  typedef enum logic [1:0] {
    MOT_OPENING     = 2'd0,
    MOT_CLOSING     = 2'd1,
    MOT_STOP_OPENED = 2'd2,
    MOT_STOP_CLOSED = 2'd3
  } motion_t;

  typedef enum logic [1:0] {
    OP_IDLE    = 2'd0,
    OP_OPENING = 2'd1,
    OP_CLOSING = 2'd2
  } op_t;

  localparam logic [CFG_IDX_W-1:0] REG_MOTION_THRESHOLD = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STILL_MS         = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COUNTS_PER_HUND  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT_MS       = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_MS         = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ENDPOINT_TO_MS   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TRAVEL_TO_MS     = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ARRIVE_TOL       = 4'd7;

  localparam logic [CFG16_W-1:0] RST_MOTION_THRESHOLD = 16'd100;
  localparam logic [CFG16_W-1:0] RST_STILL_MS         = 16'd500;
  localparam logic [CPH_W-1:0]   RST_COUNTS_PER_HUND  = 12'd261;
  localparam logic [CFG16_W-1:0] RST_LOCKOUT_MS       = 16'd2000;
  localparam logic [CFG16_W-1:0] RST_PULSE_MS         = 16'd200;
  localparam logic [CFG16_W-1:0] RST_ENDPOINT_TO_MS   = 16'd6000;
  localparam logic [CFG16_W-1:0] RST_TRAVEL_TO_MS     = 16'd30000;
  localparam logic [TOL_W-1:0]   RST_ARRIVE_TOL       = 7'd5;

  localparam logic [DIV_STEPS-1:0] QUO_FLOOR = 23'd5;
  localparam logic [DIV_STEPS-1:0] QUO_CEIL  = 23'd32767;
  localparam logic [POS_W-1:0]     POS_MAX   = 15'd32767;

  localparam logic [TGT_W-1:0] TGT_SNAP_HIGH = 7'd90;
  localparam logic [TGT_W-1:0] TGT_SNAP_LOW  = 7'd10;
  localparam logic [TGT_W-1:0] TGT_OPEN      = 7'd100;
  localparam logic [TGT_W-1:0] TGT_CLOSED    = 7'd0;

  typedef struct packed {
    logic capture;
    logic div_start;
    logic do_motion;
    logic do_act;
    logic do_release;
    logic do_request;
    logic load_out;
  } sbc_cmd_t;

  typedef struct packed {
    logic in_is_tick;
    logic div_last;
  } sbc_stat_t;

endpackage

[rtl/sbc_if.sv]
// channel interfaces: input items, result items and the register write port
// depends on sbc_pkg for field widths

interface sbc_in_if import sbc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               command;
  logic signed [CNT_W-1:0]  encoder_count;
  logic [TGT_W-1:0]         target_hundredths;

  modport source (output valid, command, encoder_count, target_hundredths, input ready);
  modport sink   (input valid, command, encoder_count, target_hundredths, output ready);
endinterface

interface sbc_out_if import sbc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             button_level;
  logic [1:0]       operation;
  logic [POS_W-1:0] position_hundredths;
  logic [1:0]       motion;
  logic             publish;

  modport source (output valid, button_level, operation, position_hundredths, motion,
                  publish, input ready);
  modport sink   (input valid, button_level, operation, position_hundredths, motion,
                  publish, output ready);
endinterface

interface sbc_cfg_if import sbc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/single_button_cover_position_controller.sv]
// top level of the single-button cover position controller
// depends on sbc_pkg, the channel interfaces, sbc_ctrl and sbc_datapath
//
// Usage
//   in_ch  : one transaction per item: a 1 ms tick with an encoder count, a stop
//            request or a target request. One item is worked on at a time.
//   out_ch : exactly one result per item, in order, held in an output register.
//   cfg_ch : register writes, always ready; writes are to be taken only while no item
//            is in flight, which the user must ensure, as the block does not enforce it.
// Sequencing
//   a tick passes the 23-step serial divider that turns the count into hundredths,
//   then the motion, action, release and output states; a request passes the request
//   and output states. The next item is accepted once the sequencer is back in idle.
// Reset
//   synchronous active-low rst_n restores the register defaults, clears all timers,
//   sets motion to stopped after closing and the operation to idle.
// Stalls
//   a result waiting on out_ch does not block the next item from being accepted
//   and processed; that item then waits for the output register to empty.

module single_button_cover_position_controller import sbc_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  sbc_in_if.sink   in_ch,
  sbc_out_if.source out_ch,
  sbc_cfg_if.sink  cfg_ch
);

  sbc_cmd_t  cmd;
  sbc_stat_t stat;

  sbc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  sbc_datapath u_dp (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg                     (cfg_ch),
    .in_command              (in_ch.command),
    .in_encoder_count        (in_ch.encoder_count),
    .in_target_hundredths    (in_ch.target_hundredths),
    .cmd                     (cmd),
    .stat                    (stat),
    .out_button_level        (out_ch.button_level),
    .out_operation           (out_ch.operation),
    .out_position_hundredths (out_ch.position_hundredths),
    .out_motion              (out_ch.motion),
    .out_publish             (out_ch.publish)
  );

endmodule

[rtl/sbc_div.sv]
// serial restoring divider: unsigned count over counts per hundredth, one bit a cycle
// depends on sbc_pkg

module sbc_div import sbc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DIV_STEPS-1:0] dividend,
  input  logic [CPH_W-1:0]     divisor,
  output logic [DIV_STEPS-1:0] quotient,
  output logic                 last
);

  logic                 busy_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [CPH_W-1:0]     rem_r;
  logic [DIV_STEPS-1:0] quo_r;
  logic [CPH_W-1:0]     dsr_r;
  logic [CPH_W:0]       trial;
  logic [CPH_W:0]       diff;
  logic                 fits;

  always_comb begin
    trial = {rem_r, quo_r[DIV_STEPS-1]};
    diff  = trial - {1'b0, dsr_r};
    fits  = (trial >= {1'b0, dsr_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= DIV_CNT_W'(DIV_STEPS);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      // a zero divisor behaves as one
      dsr_r <= (divisor == '0) ? CPH_W'(1) : divisor;
    end else if (busy_r) begin
      rem_r <= fits ? diff[CPH_W-1:0] : trial[CPH_W-1:0];
      quo_r <= {quo_r[DIV_STEPS-2:0], fits};
    end
  end

  assign quotient = quo_r;
  assign last     = busy_r && (cnt_r == DIV_CNT_W'(1));

endmodule

[rtl/sbc_datapath.sv]
// datapath: register file, controller state, position, motion and button timing
// depends on sbc_pkg, sbc_cfg_if and sbc_div

module sbc_datapath import sbc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  sbc_cfg_if.sink                 cfg,
  input  logic [1:0]              in_command,
  input  logic signed [CNT_W-1:0] in_encoder_count,
  input  logic [TGT_W-1:0]        in_target_hundredths,
  input  sbc_cmd_t                cmd,
  output sbc_stat_t               stat,
  output logic                    out_button_level,
  output logic [1:0]              out_operation,
  output logic [POS_W-1:0]        out_position_hundredths,
  output logic [1:0]              out_motion,
  output logic                    out_publish
);

  // configuration registers
  logic [CFG16_W-1:0] thr_r, still_r, lockout_ms_r, pulse_r, endpoint_r, travel_r;
  logic [CPH_W-1:0]   cph_r;
  logic [TOL_W-1:0]   tol_r;

  // captured transaction
  logic [1:0]       cmd_r;
  logic [CNT_W-1:0] raw_r;
  logic [TGT_W-1:0] tgt_in_r;

  // controller state
  logic [TIME_W-1:0] time_r, last_move_r, deadline_r, lockout_r, release_r;
  logic [CNT_W-1:0]  last_cnt_r;
  logic [POS_W-1:0]  pos_r;
  motion_t           motion_r;
  op_t               op_r;
  logic [TGT_W-1:0]  target_r;
  logic              button_r;
  logic              pub_r;

  logic [DIV_STEPS-1:0] dividend, quotient;
  logic                 div_last;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r        <= RST_MOTION_THRESHOLD;
      still_r      <= RST_STILL_MS;
      cph_r        <= RST_COUNTS_PER_HUND;
      lockout_ms_r <= RST_LOCKOUT_MS;
      pulse_r      <= RST_PULSE_MS;
      endpoint_r   <= RST_ENDPOINT_TO_MS;
      travel_r     <= RST_TRAVEL_TO_MS;
      tol_r        <= RST_ARRIVE_TOL;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_MOTION_THRESHOLD: thr_r        <= cfg.data;
        REG_STILL_MS:         still_r      <= cfg.data;
        REG_COUNTS_PER_HUND:  cph_r        <= cfg.data[CPH_W-1:0];
        REG_LOCKOUT_MS:       lockout_ms_r <= cfg.data;
        REG_PULSE_MS:         pulse_r      <= cfg.data;
        REG_ENDPOINT_TO_MS:   endpoint_r   <= cfg.data;
        REG_TRAVEL_TO_MS:     travel_r     <= cfg.data;
        REG_ARRIVE_TOL:       tol_r        <= cfg.data[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // negative counts always land below the floor, so divide zero instead
  assign dividend = in_encoder_count[CNT_W-1] ? '0 : in_encoder_count[DIV_STEPS-1:0];

  sbc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (cph_r),
    .quotient (quotient),
    .last     (div_last)
  );

  assign stat.in_is_tick = (in_command == CMD_TICK);
  assign stat.div_last   = div_last;

  // motion stage terms
  logic [TIME_W-1:0] now_inc;
  logic [POS_W-1:0]  pos_calc;
  logic [CNT_W:0]    delta, delta_mag;
  logic              moved, still;

  always_comb begin
    now_inc = time_r + 1'b1;
    if (quotient < QUO_FLOOR) begin
      pos_calc = '0;
    end else if (quotient > QUO_CEIL) begin
      pos_calc = POS_MAX;
    end else begin
      pos_calc = quotient[POS_W-1:0];
    end
    delta     = {raw_r[CNT_W-1], raw_r} - {last_cnt_r[CNT_W-1], last_cnt_r};
    delta_mag = delta[CNT_W] ? (~delta + 1'b1) : delta;
    moved     = (delta_mag > {{(CNT_W+1-CFG16_W){1'b0}}, thr_r});
    still     = ((now_inc - last_move_r) > {{(TIME_W-CFG16_W){1'b0}}, still_r});
  end

  // act stage terms, time_r already holds the new time
  logic              pending, unlocked, matched, end_target, arrived;
  logic [POS_W:0]    err, err_mag;
  op_t               op_follow;

  always_comb begin
    pending  = (time_r < deadline_r);
    unlocked = (time_r > lockout_r);
    matched  = (motion_r == MOT_OPENING && op_r == OP_OPENING) ||
               (motion_r == MOT_CLOSING && op_r == OP_CLOSING) ||
               ((motion_r == MOT_STOP_OPENED || motion_r == MOT_STOP_CLOSED) &&
                op_r == OP_IDLE);
    end_target = (target_r == TGT_OPEN) || (target_r == TGT_CLOSED);
    err        = {{(POS_W+1-TGT_W){1'b0}}, target_r} - {1'b0, pos_r};
    err_mag    = err[POS_W] ? (~err + 1'b1) : err;
    arrived    = (err_mag < {{(POS_W+1-TOL_W){1'b0}}, tol_r});
    case (motion_r)
      MOT_OPENING: op_follow = OP_OPENING;
      MOT_CLOSING: op_follow = OP_CLOSING;
      default:     op_follow = OP_IDLE;
    endcase
  end

  // request terms
  logic [TGT_W-1:0] tgt_snap;

  always_comb begin
    if (tgt_in_r > TGT_SNAP_HIGH) begin
      tgt_snap = TGT_OPEN;
    end else if (tgt_in_r < TGT_SNAP_LOW) begin
      tgt_snap = TGT_CLOSED;
    end else begin
      tgt_snap = tgt_in_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r    <= in_command;
      raw_r    <= in_encoder_count;
      tgt_in_r <= in_target_hundredths;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r      <= '0;
      last_cnt_r  <= '0;
      pos_r       <= '0;
      motion_r    <= MOT_STOP_CLOSED;
      op_r        <= OP_IDLE;
      target_r    <= '0;
      last_move_r <= '0;
      deadline_r  <= '0;
      lockout_r   <= '0;
      release_r   <= '0;
      button_r    <= 1'b0;
      pub_r       <= 1'b0;
    end else begin
      if (cmd.capture) begin
        pub_r <= 1'b0;
      end

      if (cmd.do_motion) begin
        time_r <= now_inc;
        pos_r  <= pos_calc;
        if (moved) begin
          last_cnt_r  <= raw_r;
          pub_r       <= 1'b1;
          motion_r    <= delta[CNT_W] ? MOT_CLOSING : MOT_OPENING;
          last_move_r <= now_inc;
        end else if (still) begin
          if (motion_r == MOT_OPENING) begin
            motion_r <= MOT_STOP_OPENED;
          end else if (motion_r == MOT_CLOSING) begin
            motion_r <= MOT_STOP_CLOSED;
          end
        end
      end

      if (cmd.do_act) begin
        if (pending) begin
          if (unlocked) begin
            if (!matched || (!end_target && arrived)) begin
              // button pulse
              lockout_r <= time_r + {{(TIME_W-CFG16_W){1'b0}}, lockout_ms_r};
              release_r <= time_r + {{(TIME_W-CFG16_W){1'b0}}, pulse_r};
              button_r  <= 1'b1;
            end
            if (matched && (end_target || arrived)) begin
              deadline_r <= '0;
            end
            if (matched && !end_target && arrived) begin
              op_r <= OP_IDLE;
            end
          end
        end else begin
          op_r <= op_follow;
          if (op_follow != op_r) begin
            pub_r <= 1'b1;
          end
        end
      end

      if (cmd.do_release) begin
        if (release_r != '0 && release_r < time_r) begin
          button_r  <= 1'b0;
          release_r <= '0;
        end
      end

      if (cmd.do_request) begin
        case (cmd_r)
          CMD_STOP: begin
            op_r       <= OP_IDLE;
            deadline_r <= time_r + {{(TIME_W-CFG16_W){1'b0}}, endpoint_r};
          end
          CMD_TARGET: begin
            target_r <= tgt_snap;
            if (tgt_snap == TGT_OPEN || tgt_snap == TGT_CLOSED) begin
              deadline_r <= time_r + {{(TIME_W-CFG16_W){1'b0}}, endpoint_r};
            end else begin
              deadline_r <= time_r + {{(TIME_W-CFG16_W){1'b0}}, travel_r};
            end
            op_r  <= ({{(POS_W-TGT_W){1'b0}}, tgt_snap} > pos_r) ? OP_OPENING : OP_CLOSING;
            pub_r <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_button_level        <= button_r;
      out_operation           <= op_r;
      out_position_hundredths <= pos_r;
      out_motion              <= motion_r;
      out_publish             <= pub_r;
    end
  end

endmodule

[rtl/sbc_ctrl.sv]
// sequencer: steps a tick through divide, motion, action, release and output stages,
// and a request through request and output stages; depends on sbc_pkg

module sbc_ctrl import sbc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output sbc_cmd_t  cmd,
  input  sbc_stat_t stat
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_MOTION,
    ST_ACT,
    ST_RELEASE,
    ST_REQUEST,
    ST_OUTPUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (stat.in_is_tick) begin
            cmd.div_start = 1'b1;
            state_nxt     = ST_DIVIDE;
          end else begin
            state_nxt = ST_REQUEST;
          end
        end
      end
      ST_DIVIDE: begin
        if (stat.div_last) begin
          state_nxt = ST_MOTION;
        end
      end
      ST_MOTION: begin
        cmd.do_motion = 1'b1;
        state_nxt     = ST_ACT;
      end
      ST_ACT: begin
        cmd.do_act = 1'b1;
        state_nxt  = ST_RELEASE;
      end
      ST_RELEASE: begin
        cmd.do_release = 1'b1;
        state_nxt      = ST_OUTPUT;
      end
      ST_REQUEST: begin
        cmd.do_request = 1'b1;
        state_nxt      = ST_OUTPUT;
      end
      ST_OUTPUT: begin
        // hold until the result register is free or being emptied
        if (slot_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/sbc_checker.sv]
// port-level checks for the cover position controller, bound to the top level
// depends on sbc_pkg

module sbc_checker import sbc_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic             out_button_level,
  input logic [1:0]       out_operation,
  input logic [POS_W-1:0] out_position_hundredths,
  input logic [1:0]       out_motion,
  input logic             out_publish
);

  logic       in_acc, out_acc;
  logic [1:0] open_r;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // transactions accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= '0;
    end else begin
      open_r <= open_r + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("input accepted while previous transaction still in work");

  a_bounded_open: assert property (@(posedge clk) disable iff (!rst_n)
    (open_r <= 2'd2) && (!out_valid || open_r != 2'd0))
    else $error("result count does not match accepted transactions");

  a_position_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_position_hundredths == '0 || out_position_hundredths >= 15'd5))
    else $error("position below floor not forced to zero");

  a_operation_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_operation == OP_IDLE || out_operation == OP_OPENING ||
                   out_operation == OP_CLOSING))
    else $error("operation outside defined codes");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_button_level, out_operation, out_position_hundredths,
               out_motion, out_publish}))
    else $error("stalled result changed");

endmodule

bind single_button_cover_position_controller sbc_checker u_sbc_checker (
  .clk                     (clk),
  .rst_n                   (rst_n),
  .in_valid                (in_ch.valid),
  .in_ready                (in_ch.ready),
  .out_valid               (out_ch.valid),
  .out_ready               (out_ch.ready),
  .out_button_level        (out_ch.button_level),
  .out_operation           (out_ch.operation),
  .out_position_hundredths (out_ch.position_hundredths),
  .out_motion              (out_ch.motion),
  .out_publish             (out_ch.publish)
);
